// ===== rtl/sds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Shared sizes, types and register codes of the strided 3-D local maximum
// seeder: volume limits, buffer address widths and the voxel type.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int VOX_W      = 8;
    localparam int DIM_W      = 9;
    localparam int DEPTH_W    = 16;
    localparam int STEP_W     = 8;
    localparam int LABEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int X_W = $clog2(MAX_WIDTH);
    localparam int Y_W = $clog2(MAX_HEIGHT);
    localparam int Z_W = DEPTH_W;

    localparam int LINE_AW  = $clog2(MAX_WIDTH);
    localparam int PLANE_AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CNT_W    = PLANE_AW;
    localparam int AREA_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LAG_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

    // window rows: row a*3+b carries the stream delayed by a planes and b lines
    localparam int N_ROWS     = 9;
    localparam int CENTER_ROW = 4;

    localparam logic [LABEL_W:0] LABEL_LIMIT = {1'b0, {LABEL_W{1'b1}}};

    localparam int RST_WIDTH  = 256;
    localparam int RST_HEIGHT = 256;
    localparam int RST_DEPTH  = 256;
    localparam int RST_STEP   = 1;
    localparam int RST_W_EFF  = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H_EFF  = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
    localparam int RST_AREA   = RST_W_EFF * RST_H_EFF;
    localparam int RST_LAG    = RST_AREA + RST_W_EFF + 1;

    typedef logic [VOX_W-1:0] t_voxel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME_WIDTH,
        CFG_VOLUME_HEIGHT,
        CFG_VOLUME_DEPTH,
        CFG_STEP_X,
        CFG_STEP_Y,
        CFG_STEP_Z
    } t_cfg_reg;

endpackage

// ===== rtl/sds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sds_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sds_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_window
// 3x3x3 voxel window: two taps per row stream and a strict-maximum test of
// the centre voxel against its 26 neighbours.
// ----------------------------------------------------------------------------
module sds_window
    import sds_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_voxel i_rows [N_ROWS],
    output logic   o_is_max
);

    t_voxel r_tap1 [N_ROWS];
    t_voxel r_tap2 [N_ROWS];
    t_voxel center;
    logic   is_max;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int r = 0; r < N_ROWS; r++) begin
                r_tap2[r] <= r_tap1[r];
                r_tap1[r] <= i_rows[r];
            end
        end
    end

    always_comb begin
        center = r_tap1[CENTER_ROW];
        is_max = (center != '0);
        for (int r = 0; r < N_ROWS; r++) begin
            if (i_rows[r] >= center) begin
                is_max = 1'b0;
            end
            if (r_tap2[r] >= center) begin
                is_max = 1'b0;
            end
            if (r != CENTER_ROW && r_tap1[r] >= center) begin
                is_max = 1'b0;
            end
        end
    end

    assign o_is_max = is_max;

endmodule

// ===== rtl/strided_3d_local_maximum_seeder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_3d_local_maximum_seeder
// Streams voxels in raster order through line and plane buffers, tests the
// lagging centre voxel for a strict 26-neighbour maximum on the stride grid
// and hands out sequential seed labels with a sticky overflow flag.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  voxel    | i_vox_valid / o_vox_stall  | i_voxel_value, i_last_voxel
//  result   | o_res_valid / i_res_stall  | o_center_valid, o_seed_label,
//           |                            | o_label_overflow
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One voxel beat per cycle while o_vox_stall is low; a result beat takes the
//  path buffer read register -> window compare -> result register.
//  Reset clears counters, labels and handshake state; the line and plane
//  buffers are not cleared and fill from the stream.
//  A result stall holds the result register; o_vox_stall rises only when both
//  the window stage and the result register are full.
// ----------------------------------------------------------------------------
module strided_3d_local_maximum_seeder
    import sds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vox_valid,
    output logic                  o_vox_stall,
    input  logic [VOX_W-1:0]      i_voxel_value,
    input  logic                  i_last_voxel,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic                  o_center_valid,
    output logic [LABEL_W-1:0]    o_seed_label,
    output logic                  o_label_overflow,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int limit);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > limit) begin
            res = DIM_W'(limit);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [STEP_W-1:0] step_inc(input logic [STEP_W-1:0] ph,
                                                   input logic [STEP_W-1:0] s);
        logic [STEP_W:0]   nxt;
        logic [STEP_W-1:0] s_eff;
        logic [STEP_W-1:0] res;
        nxt   = {1'b0, ph} + (STEP_W+1)'(1);
        s_eff = (s == '0) ? STEP_W'(1) : s;
        res   = (nxt >= {1'b0, s_eff}) ? '0 : nxt[STEP_W-1:0];
        return res;
    endfunction

    // configuration
    logic [DIM_W-1:0]   r_w_eff, r_h_eff, n_w_eff, n_h_eff;
    logic [DEPTH_W-1:0] r_cfg_d, n_cfg_d;
    logic [STEP_W-1:0]  r_step_x, r_step_y, r_step_z;
    logic [STEP_W-1:0]  n_step_x, n_step_y, n_step_z;
    logic [AREA_W-1:0]  r_area, n_area;
    logic [LAG_W-1:0]   r_lag, n_lag;
    logic               cfg_we;

    // position tracking
    logic [CNT_W-1:0]   r_cnt;
    logic [X_W-1:0]     r_pos_x, n_pos_x, r_cx, n_cx;
    logic [Y_W-1:0]     r_pos_y, n_pos_y, r_cy, n_cy;
    logic [Z_W-1:0]     r_pos_z, n_pos_z, r_cz, n_cz;
    logic [LAG_W-1:0]   r_dcnt, n_dcnt;
    logic [STEP_W-1:0]  r_ph_x, r_ph_y, r_ph_z, n_ph_x, n_ph_y, n_ph_z;

    // window stage and result register
    logic               r_s1_vld;
    t_voxel             r_s1_voxel;
    logic               r_s1_last, r_s1_cvalid, r_s1_cand;
    logic [CNT_W-1:0]   r_s1_addr;
    logic               r_out_vld, r_out_cvalid, r_out_ovf;
    logic [LABEL_W-1:0] r_out_label;
    logic [LABEL_W:0]   r_next_label, n_next_label;
    logic               r_ovf, n_ovf, out_ovf;
    logic [LABEL_W-1:0] label;

    logic               out_free, s1_adv, in_take;
    logic               started, c_valid, cand;
    logic               x_wrap, y_wrap, restart, cx_wrap, cy_wrap;
    logic [DIM_W-1:0]   px1, py1, cx1, cy1;
    logic [LINE_AW-1:0] line_ra;
    logic [PLANE_AW-1:0] plane_ra;
    logic               is_max, seed;

    wire t_voxel rows [N_ROWS];

    // ---------------- configuration port ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_w_eff  = r_w_eff;
        n_h_eff  = r_h_eff;
        n_cfg_d  = r_cfg_d;
        n_step_x = r_step_x;
        n_step_y = r_step_y;
        n_step_z = r_step_z;
        if (cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_VOLUME_WIDTH:  n_w_eff  = clamp_dim(i_cfg_data[DIM_W-1:0], MAX_WIDTH);
                CFG_VOLUME_HEIGHT: n_h_eff  = clamp_dim(i_cfg_data[DIM_W-1:0], MAX_HEIGHT);
                CFG_VOLUME_DEPTH:  n_cfg_d  = i_cfg_data[DEPTH_W-1:0];
                CFG_STEP_X:        n_step_x = i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:        n_step_y = i_cfg_data[STEP_W-1:0];
                CFG_STEP_Z:        n_step_z = i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
        n_area = AREA_W'(n_w_eff) * AREA_W'(n_h_eff);
        n_lag  = LAG_W'(n_area) + LAG_W'(n_w_eff) + LAG_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff  <= DIM_W'(RST_W_EFF);
            r_h_eff  <= DIM_W'(RST_H_EFF);
            r_cfg_d  <= DEPTH_W'(RST_DEPTH);
            r_step_x <= STEP_W'(RST_STEP);
            r_step_y <= STEP_W'(RST_STEP);
            r_step_z <= STEP_W'(RST_STEP);
            r_area   <= AREA_W'(RST_AREA);
            r_lag    <= LAG_W'(RST_LAG);
        end else if (cfg_we) begin
            r_w_eff  <= n_w_eff;
            r_h_eff  <= n_h_eff;
            r_cfg_d  <= n_cfg_d;
            r_step_x <= n_step_x;
            r_step_y <= n_step_y;
            r_step_z <= n_step_z;
            r_area   <= n_area;
            r_lag    <= n_lag;
        end
    end

    // ---------------- handshake ----------------
    assign out_free    = !r_out_vld || !i_res_stall;
    assign s1_adv      = r_s1_vld && out_free;
    assign o_vox_stall = r_s1_vld && !out_free;
    assign in_take     = i_vox_valid && !o_vox_stall;

    // ---------------- centre position and grid test ----------------
    assign started = (r_dcnt >= r_lag);
    assign c_valid = started && (r_cz < r_cfg_d);
    assign cx1     = DIM_W'(r_cx) + DIM_W'(1);
    assign cy1     = DIM_W'(r_cy) + DIM_W'(1);
    assign cx_wrap = (cx1 >= r_w_eff);
    assign cy_wrap = (cy1 >= r_h_eff);
    assign cand    = c_valid
                  && (r_cx != '0) && (DIM_W'(r_cx) + DIM_W'(2) <= r_w_eff)
                  && (r_cy != '0) && (DIM_W'(r_cy) + DIM_W'(2) <= r_h_eff)
                  && (r_cz != '0)
                  && ({1'b0, r_cz} + (Z_W+1)'(2) <= {1'b0, r_cfg_d})
                  && (r_ph_x == '0) && (r_ph_y == '0) && (r_ph_z == '0);

    assign px1     = DIM_W'(r_pos_x) + DIM_W'(1);
    assign py1     = DIM_W'(r_pos_y) + DIM_W'(1);
    assign x_wrap  = (px1 >= r_w_eff);
    assign y_wrap  = (py1 >= r_h_eff);
    assign restart = i_last_voxel || (x_wrap && y_wrap && (&r_pos_z));

    always_comb begin
        n_pos_x = X_W'(px1);
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        if (x_wrap) begin
            n_pos_x = '0;
            n_pos_y = y_wrap ? '0 : Y_W'(py1);
            if (y_wrap) begin
                n_pos_z = r_pos_z + Z_W'(1);
            end
        end
        if (i_last_voxel) begin
            n_pos_x = '0;
            n_pos_y = '0;
            n_pos_z = '0;
        end

        n_dcnt = started ? r_dcnt : r_dcnt + LAG_W'(1);
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_cz   = r_cz;
        n_ph_x = r_ph_x;
        n_ph_y = r_ph_y;
        n_ph_z = r_ph_z;
        if (started) begin
            n_cx   = cx_wrap ? '0 : X_W'(cx1);
            n_ph_x = (cx_wrap || r_cx == '0) ? '0 : step_inc(r_ph_x, r_step_x);
            if (cx_wrap) begin
                n_cy   = cy_wrap ? '0 : Y_W'(cy1);
                n_ph_y = (cy_wrap || r_cy == '0) ? '0 : step_inc(r_ph_y, r_step_y);
                if (cy_wrap) begin
                    n_cz   = r_cz + Z_W'(1);
                    n_ph_z = (r_cz == '0) ? '0 : step_inc(r_ph_z, r_step_z);
                end
            end
        end
        if (restart) begin
            n_dcnt = '0;
            n_cx   = '0;
            n_cy   = '0;
            n_cz   = '0;
            n_ph_x = '0;
            n_ph_y = '0;
            n_ph_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_dcnt  <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_ph_x  <= '0;
            r_ph_y  <= '0;
            r_ph_z  <= '0;
        end else if (in_take) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_dcnt  <= n_dcnt;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_cz    <= n_cz;
            r_ph_x  <= n_ph_x;
            r_ph_y  <= n_ph_y;
            r_ph_z  <= n_ph_z;
        end
    end

    // ---------------- line and plane buffers ----------------
    assign line_ra  = r_cnt[LINE_AW-1:0] - LINE_AW'(r_w_eff);
    assign plane_ra = r_cnt[PLANE_AW-1:0] - PLANE_AW'(r_area);
    assign rows[0]  = r_s1_voxel;

    for (genvar g = 1; g < N_ROWS; g++) begin : g_delay
        if (g % 3 == 0) begin : g_plane
            sds_ram #(
                .ADDR_W (PLANE_AW),
                .DATA_W (VOX_W)
            ) u_ram (
                .i_clk     (i_clk),
                .i_wr_en   (s1_adv),
                .i_wr_addr (r_s1_addr[PLANE_AW-1:0]),
                .i_wr_data (rows[g-3]),
                .i_rd_en   (in_take),
                .i_rd_addr (plane_ra),
                .o_rd_data (rows[g])
            );
        end else begin : g_line
            sds_ram #(
                .ADDR_W (LINE_AW),
                .DATA_W (VOX_W)
            ) u_ram (
                .i_clk     (i_clk),
                .i_wr_en   (s1_adv),
                .i_wr_addr (r_s1_addr[LINE_AW-1:0]),
                .i_wr_data (rows[g-1]),
                .i_rd_en   (in_take),
                .i_rd_addr (line_ra),
                .o_rd_data (rows[g])
            );
        end
    end

    sds_window u_window (
        .i_clk    (i_clk),
        .i_shift  (s1_adv),
        .i_rows   (rows),
        .o_is_max (is_max)
    );

    // ---------------- window stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_take) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_voxel  <= i_voxel_value;
            r_s1_last   <= i_last_voxel;
            r_s1_cvalid <= c_valid;
            r_s1_cand   <= cand;
            r_s1_addr   <= r_cnt;
        end
    end

    // ---------------- labeling ----------------
    assign seed = r_s1_cand && is_max;

    always_comb begin
        n_next_label = r_next_label;
        n_ovf        = r_ovf;
        label        = '0;
        if (seed) begin
            if (r_ovf || r_next_label > LABEL_LIMIT) begin
                n_ovf = 1'b1;
            end else begin
                label        = r_next_label[LABEL_W-1:0];
                n_next_label = r_next_label + (LABEL_W+1)'(1);
            end
        end
        out_ovf = n_ovf;
        if (r_s1_last) begin
            n_next_label = (LABEL_W+1)'(1);
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_label <= (LABEL_W+1)'(1);
            r_ovf        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_next_label <= n_next_label;
                r_ovf        <= n_ovf;
                r_out_vld    <= 1'b1;
            end else if (out_free) begin
                r_out_vld    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_cvalid <= r_s1_cvalid;
            r_out_label  <= label;
            r_out_ovf    <= out_ovf;
        end
    end

    assign o_res_valid      = r_out_vld;
    assign o_center_valid   = r_out_cvalid;
    assign o_seed_label     = r_out_label;
    assign o_label_overflow = r_out_ovf;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strided 3-D local maximum seeder. A directed
// table exercises reset geometry, degenerate 1x1 volumes, zero depth and zero
// steps. It is followed by a small volume sent back to back with no gaps or
// stalls, a huge depth, and then random small volumes, some cut short and
// some overlong. The bench takes each result beat from the directed table or
// predicts it from its own model of the voxel window and compares every
// field. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import sds_pkg::*;

    localparam int HIST_DEPTH     = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_VOXELS  = 380;
    localparam int N_DIRECTED     = 29;

    typedef struct packed {
        logic               center_valid;
        logic [LABEL_W-1:0] seed_label;
        logic               label_overflow;
    } t_result;

    typedef struct packed {
        bit                    is_cfg;
        t_cfg_reg              reg_sel;
        logic [CFG_DATA_W-1:0] cfg_value;
        t_voxel                voxel;
        bit                    last;
        bit                    typed;
        t_result               want;
    } t_row;

    typedef enum int {FILL_NOISE, FILL_SPARSE, FILL_LATTICE, FILL_TIES} t_fill;

    localparam t_result RES_EMPTY = '{center_valid: 1'b0, seed_label: '0, label_overflow: 1'b0};
    localparam t_result RES_PLAIN = '{center_valid: 1'b1, seed_label: '0, label_overflow: 1'b0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_vox_valid;
    logic                  o_vox_stall;
    logic [VOX_W-1:0]      i_voxel_value;
    logic                  i_last_voxel;
    logic                  o_res_valid;
    logic                  i_res_stall;
    logic                  o_center_valid;
    logic [LABEL_W-1:0]    o_seed_label;
    logic                  o_label_overflow;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    strided_3d_local_maximum_seeder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vox_valid      (i_vox_valid),
        .o_vox_stall      (o_vox_stall),
        .i_voxel_value    (i_voxel_value),
        .i_last_voxel     (i_last_voxel),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_center_valid   (o_center_valid),
        .o_seed_label     (o_seed_label),
        .o_label_overflow (o_label_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // seeder state as the bench sees it
    bit [VOX_W-1:0]     voxel_store [HIST_DEPTH];
    int                 store_wr      = 0;
    int                 pos_x         = 0;
    int                 pos_y         = 0;
    int                 pos_z         = 0;
    int                 next_label    = 1;
    bit                 overflow_seen = 1'b0;
    logic [DIM_W-1:0]   cfg_width     = DIM_W'(RST_WIDTH);
    logic [DIM_W-1:0]   cfg_height    = DIM_W'(RST_HEIGHT);
    logic [DEPTH_W-1:0] cfg_depth     = DEPTH_W'(RST_DEPTH);
    logic [STEP_W-1:0]  cfg_step_x    = STEP_W'(RST_STEP);
    logic [STEP_W-1:0]  cfg_step_y    = STEP_W'(RST_STEP);
    logic [STEP_W-1:0]  cfg_step_z    = STEP_W'(RST_STEP);

    t_result center_results_due [$];
    t_row    directed_rows [N_DIRECTED];

    bit gaps_on        = 1'b1;
    int errors         = 0;
    int voxels_sent    = 0;
    int volumes_sent   = 0;
    int seeds_seen     = 0;
    int overflow_beats = 0;
    int quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_voxel stored_back(longint back);
        longint p;
        p = (longint'(store_wr) + HIST_DEPTH - (back % HIST_DEPTH)) % HIST_DEPTH;
        return voxel_store[p];
    endfunction

    function automatic t_result next_center_result(t_voxel v_in, bit last);
        longint  w, h, area, lag, idx, ci, cx, cy, cz, off, sx, sy, sz;
        bit      valid, is_max;
        t_voxel  c;
        t_result r;
        w    = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h    = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
        area = w * h;
        lag  = area + w + 1;
        sx   = (cfg_step_x == 0) ? 1 : cfg_step_x;
        sy   = (cfg_step_y == 0) ? 1 : cfg_step_y;
        sz   = (cfg_step_z == 0) ? 1 : cfg_step_z;
        cx   = 0;
        cy   = 0;
        cz   = 0;
        r    = RES_EMPTY;

        voxel_store[store_wr] = v_in;
        idx   = longint'(pos_z) * area + longint'(pos_y) * w + pos_x;
        valid = idx >= lag;
        if (valid) begin
            ci    = idx - lag;
            cz    = ci / area;
            cy    = (ci % area) / w;
            cx    = ci % w;
            valid = cz < longint'(cfg_depth);
        end
        r.center_valid = valid;

        if (valid && cx >= 1 && cx + 2 <= w && cy >= 1 && cy + 2 <= h &&
            cz >= 1 && cz + 2 <= longint'(cfg_depth) &&
            (cx - 1) % sx == 0 && (cy - 1) % sy == 0 && (cz - 1) % sz == 0) begin
            c      = stored_back(lag);
            is_max = c != 0;
            for (int dz = -1; dz <= 1; dz++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dz != 0 || dy != 0 || dx != 0) begin
                            off = dz * area + dy * w + dx;
                            if (stored_back(lag - off) >= c) is_max = 1'b0;
                        end
            if (is_max) begin
                if (overflow_seen || next_label > LABEL_LIMIT) begin
                    overflow_seen = 1'b1;
                end else begin
                    r.seed_label = next_label[LABEL_W-1:0];
                    next_label   = (next_label + 1) & 'h1FF;
                end
            end
        end
        r.label_overflow = overflow_seen;

        store_wr = (store_wr + 1) % HIST_DEPTH;
        if (last) begin
            pos_x         = 0;
            pos_y         = 0;
            pos_z         = 0;
            next_label    = 1;
            overflow_seen = 1'b0;
        end else begin
            pos_x++;
            if (pos_x >= w) begin
                pos_x = 0;
                pos_y++;
                if (pos_y >= h) begin
                    pos_y = 0;
                    pos_z = (pos_z + 1) & 'hFFFF;
                end
            end
        end
        return r;
    endfunction

    function automatic t_row vox_row(t_voxel v, bit last, bit typed, t_result want);
        t_row r;
        r       = '0;
        r.voxel = v;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row cfg_row(t_cfg_reg sel, int value);
        t_row r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.reg_sel   = sel;
        r.cfg_value = CFG_DATA_W'(value);
        return r;
    endfunction

    function automatic t_voxel fill_value(t_fill fill, int x, int y, int z);
        case (fill)
            FILL_SPARSE:  return ($urandom_range(0, 9) == 0) ? VOX_W'($urandom_range(1, 255)) : '0;
            FILL_LATTICE: return (x % 2 == 1 && y % 2 == 1 && z % 2 == 1) ?
                                 VOX_W'($urandom_range(128, 255)) : VOX_W'($urandom_range(0, 127));
            FILL_TIES:    return VOX_W'($urandom_range(0, 2));
            default:      return VOX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic wait_drained();
        i_vox_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (center_results_due.size() != 0);
    endtask

    task automatic write_reg(t_cfg_reg sel, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            CFG_VOLUME_WIDTH:  cfg_width  = value[DIM_W-1:0];
            CFG_VOLUME_HEIGHT: cfg_height = value[DIM_W-1:0];
            CFG_VOLUME_DEPTH:  cfg_depth  = value[DEPTH_W-1:0];
            CFG_STEP_X:        cfg_step_x = value[STEP_W-1:0];
            CFG_STEP_Y:        cfg_step_y = value[STEP_W-1:0];
            CFG_STEP_Z:        cfg_step_z = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_voxel(t_voxel v, bit last, bit typed, t_result want);
        t_result due;
        i_cfg_valid <= 1'b0;
        while (gaps_on && $urandom_range(0, 99) < 33) begin
            i_vox_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_vox_valid   <= 1'b1;
        i_voxel_value <= v;
        i_last_voxel  <= last;
        do @(posedge i_clk); while (o_vox_stall);
        due = next_center_result(v, last);
        if (typed) due = want;
        center_results_due = {center_results_due, due};
        voxels_sent++;
    endtask

    task automatic set_geometry(int w, int h, int d, int sx, int sy, int sz);
        wait_drained();
        write_reg(CFG_VOLUME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_VOLUME_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_VOLUME_DEPTH, CFG_DATA_W'(d));
        write_reg(CFG_STEP_X, CFG_DATA_W'(sx));
        write_reg(CFG_STEP_Y, CFG_DATA_W'(sy));
        write_reg(CFG_STEP_Z, CFG_DATA_W'(sz));
    endtask

    task automatic stream_volume(int we, int he, int n, t_fill fill, bit pause_ok);
        int x, y, z;
        x = 0;
        y = 0;
        z = 0;
        for (int i = 0; i < n; i++) begin
            if (pause_ok && $urandom_range(0, 63) == 0) wait_drained();
            send_voxel(fill_value(fill, x, y, z), i == n - 1, 1'b0, RES_EMPTY);
            x++;
            if (x >= we) begin
                x = 0;
                y++;
                if (y >= he) begin
                    y = 0;
                    z++;
                end
            end
        end
        volumes_sent++;
    endtask

    task automatic report_field(string field, int want, int got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (center_results_due.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with no voxel pending", $time);
            end else begin
                want = center_results_due.pop_front();
                if (o_center_valid !== want.center_valid)
                    report_field("center_valid", want.center_valid, o_center_valid);
                if (o_seed_label !== want.seed_label)
                    report_field("seed_label", want.seed_label, o_seed_label);
                if (o_label_overflow !== want.label_overflow)
                    report_field("label_overflow", want.label_overflow, o_label_overflow);
            end
            if (o_seed_label != 0) seeds_seen++;
            if (o_label_overflow) overflow_beats++;
        end
        i_res_stall <= gaps_on && ($urandom_range(0, 99) < 33);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_vox_valid && !o_vox_stall) || (o_res_valid && !i_res_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int w, h, d, we, he, n, random_voxels;
        i_rst_n       <= 1'b0;
        i_vox_valid   <= 1'b0;
        i_voxel_value <= '0;
        i_last_voxel  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_VOLUME_WIDTH;
        i_cfg_data    <= '0;
        i_res_stall   <= 1'b0;
        directed_rows = '{
            vox_row(8'hFF, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'h00, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'h80, 1'b1, 1'b1, RES_EMPTY),
            cfg_row(CFG_VOLUME_WIDTH, 0),
            cfg_row(CFG_VOLUME_HEIGHT, 0),
            cfg_row(CFG_VOLUME_DEPTH, 0),
            vox_row(8'h01, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'hFE, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'h7F, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'h55, 1'b1, 1'b1, RES_EMPTY),
            cfg_row(CFG_VOLUME_DEPTH, 2),
            vox_row(8'hAA, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'h33, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'hCC, 1'b0, 1'b1, RES_EMPTY),
            vox_row(8'h0F, 1'b0, 1'b1, RES_PLAIN),
            vox_row(8'hF0, 1'b0, 1'b1, RES_PLAIN),
            vox_row(8'h11, 1'b1, 1'b1, RES_EMPTY),
            cfg_row(CFG_STEP_X, 0),
            cfg_row(CFG_STEP_Y, 0),
            cfg_row(CFG_STEP_Z, 0),
            cfg_row(CFG_VOLUME_WIDTH, 3),
            cfg_row(CFG_VOLUME_HEIGHT, 1),
            cfg_row(CFG_VOLUME_DEPTH, 1),
            vox_row(8'hFF, 1'b0, 1'b0, RES_EMPTY),
            vox_row(8'h00, 1'b0, 1'b0, RES_EMPTY),
            vox_row(8'hFF, 1'b0, 1'b0, RES_EMPTY),
            vox_row(8'h10, 1'b0, 1'b0, RES_EMPTY),
            vox_row(8'h20, 1'b0, 1'b0, RES_EMPTY),
            vox_row(8'h30, 1'b1, 1'b0, RES_EMPTY)
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_drained();
                write_reg(directed_rows[k].reg_sel, directed_rows[k].cfg_value);
            end else begin
                send_voxel(directed_rows[k].voxel, directed_rows[k].last,
                           directed_rows[k].typed, directed_rows[k].want);
            end
        end

        // back-to-back beats with no gaps or stalls
        gaps_on = 1'b0;
        set_geometry(5, 5, 5, 1, 1, 1);
        stream_volume(5, 5, 125, FILL_LATTICE, 1'b0);
        gaps_on = 1'b1;
        set_geometry(4, 4, 65535, 2, 2, 1);
        stream_volume(4, 4, 80, FILL_NOISE, 1'b1);

        random_voxels = 0;
        while (random_voxels < RANDOM_VOXELS) begin
            w  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            d  = $urandom_range(0, 6);
            set_geometry(w, h, d, $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 3));
            we = (w == 0) ? 1 : w;
            he = (h == 0) ? 1 : h;
            n  = we * he * ((d == 0) ? 3 : d);
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, n);
                1: n = n + $urandom_range(1, n);
                default: ;
            endcase
            if (n > RANDOM_VOXELS - random_voxels) n = RANDOM_VOXELS - random_voxels;
            stream_volume(we, he, n, t_fill'($urandom_range(0, 3)), 1'b1);
            random_voxels += n;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("run: %0d voxels in %0d streamed volumes plus directed rows", voxels_sent,
                 volumes_sent);
        $display("run: %0d seed labels and %0d overflow beats compared", seeds_seen,
                 overflow_beats);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sds_pkg.sv
rtl/sds_ram.sv
rtl/sds_window.sv
rtl/strided_3d_local_maximum_seeder.sv
test/tb.sv
